FILE: hdl/bccs_pkg.sv
// Shared types, widths and codes for the copy-rectangle setup pipeline.
`default_nettype none

package bccs_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = $clog2(MAX_DIM) + 1;
    localparam int BPP_W     = 3;
    localparam int IN_W      = 16;
    localparam int FIX_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int RND_W     = FIX_W + 1 - FRAC_W;
    localparam int SUM_W     = IN_W + 2;
    localparam int CLP_W     = 20;
    localparam int OFS_W     = 26;
    localparam int RB_W      = 15;
    localparam int STAT_W    = 2;
    localparam int ORD_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SURF_W,
        REG_SURF_H,
        REG_STRIDE,
        REG_BPP,
        REG_CLIP_L,
        REG_CLIP_T,
        REG_CLIP_R,
        REG_CLIP_B
    } t_reg_idx;

    typedef enum logic [STAT_W-1:0] {
        ST_COPY,
        ST_OUTSIDE,
        ST_EMPTY,
        ST_SAME
    } t_status;

    typedef enum logic [ORD_W-1:0] {
        ORD_DOWN,
        ORD_UP,
        ORD_ROW_SAFE
    } t_order;

    typedef struct packed {
        logic [DIM_W-1:0] surf_w;
        logic [DIM_W-1:0] surf_h;
        logic [DIM_W-1:0] stride;
        logic [BPP_W-1:0] bpp;
        logic [DIM_W-1:0] clip_l;
        logic [DIM_W-1:0] clip_t;
        logic [DIM_W-1:0] clip_r;
        logic [DIM_W-1:0] clip_b;
    } t_cfg;

    // Geometry carried through the clipping stages
    typedef struct packed {
        logic                    reject;
        logic signed [CLP_W-1:0] xs;
        logic signed [CLP_W-1:0] ys;
        logic signed [CLP_W-1:0] w;
        logic signed [CLP_W-1:0] h;
        logic signed [CLP_W-1:0] xd;
        logic signed [CLP_W-1:0] yd;
    } t_geom;

    // Classified item with row products, before the final offset scaling
    typedef struct packed {
        t_status          status;
        logic [OFS_W-1:0] prod_s;
        logic [OFS_W-1:0] prod_d;
        logic [DIM_W-1:0] xs;
        logic [DIM_W-1:0] xd;
        logic [RB_W-1:0]  row_bytes;
        logic [DIM_W-1:0] row_count;
        t_order           order;
    } t_cls;

    typedef struct packed {
        t_status          status;
        logic [OFS_W-1:0] src_offset;
        logic [OFS_W-1:0] dst_offset;
        logic [RB_W-1:0]  row_bytes;
        logic [DIM_W-1:0] row_count;
        t_order           order;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/blit_copy_clip_setup.sv
// Throughput: one item per cycle while i_stall is low; five register stages, each with its own valid bit.
// A stalled output holds only the last stage; empty stages upstream keep filling.
// o_stall rises only when all five stages hold items and i_stall is high.
// Reset (synchronous, active low) clears all valid bits and sets the registers
// to their reset values (bytes_per_pixel 4, all others 0).
`default_nettype none

module blit_copy_clip_setup (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bccs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bccs_pkg::DIM_W-1:0]          i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [bccs_pkg::IN_W-1:0]    i_src_x,
    input  wire logic signed [bccs_pkg::IN_W-1:0]    i_src_y,
    input  wire logic signed [bccs_pkg::IN_W-1:0]    i_copy_width,
    input  wire logic signed [bccs_pkg::IN_W-1:0]    i_copy_height,
    input  wire logic signed [bccs_pkg::FIX_W-1:0]   i_dest_x_fixed,
    input  wire logic signed [bccs_pkg::FIX_W-1:0]   i_dest_y_fixed,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [bccs_pkg::STAT_W-1:0]              o_status,
    output logic [bccs_pkg::OFS_W-1:0]               o_src_offset,
    output logic [bccs_pkg::OFS_W-1:0]               o_dst_offset,
    output logic [bccs_pkg::RB_W-1:0]                o_row_bytes,
    output logic [bccs_pkg::DIM_W-1:0]               o_row_count,
    output logic [bccs_pkg::ORD_W-1:0]               o_copy_order
);
    import bccs_pkg::*;

    t_cfg  cfg;
    t_geom geom1;
    t_geom geom3;
    t_res  res;
    logic  vld1;
    logic  vld3;
    logic  rdy_front;
    logic  rdy_clip;
    logic  rdy_offs;

    // Hold the configuration registers
    bccs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Check the source and round the destination
    bccs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_valid),
        .o_ready        (rdy_front),
        .i_src_x        (i_src_x),
        .i_src_y        (i_src_y),
        .i_copy_width   (i_copy_width),
        .i_copy_height  (i_copy_height),
        .i_dest_x_fixed (i_dest_x_fixed),
        .i_dest_y_fixed (i_dest_y_fixed),
        .o_valid        (vld1),
        .i_ready        (rdy_clip),
        .o_geom         (geom1)
    );

    // Clip to the scissor box
    bccs_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (vld1),
        .o_ready (rdy_clip),
        .i_geom  (geom1),
        .o_valid (vld3),
        .i_ready (rdy_offs),
        .o_geom  (geom3)
    );

    // Classify and form offsets
    bccs_offs u_offs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (vld3),
        .o_ready (rdy_offs),
        .i_geom  (geom3),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_res   (res)
    );

    assign o_stall      = !rdy_front;
    assign o_status     = res.status;
    assign o_src_offset = res.src_offset;
    assign o_dst_offset = res.dst_offset;
    assign o_row_bytes  = res.row_bytes;
    assign o_row_count  = res.row_count;
    assign o_copy_order = res.order;

endmodule

`default_nettype wire

FILE: hdl/bccs_cfg.sv
// Configuration register file of the copy-rectangle setup block.
`default_nettype none

module bccs_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bccs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bccs_pkg::DIM_W-1:0]     i_cfg_data,
    output bccs_pkg::t_cfg                      o_cfg
);
    import bccs_pkg::*;

    t_cfg r_cfg;

    // Write one register per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{surf_w: '0, surf_h: '0, stride: '0, bpp: BPP_RESET,
                       clip_l: '0, clip_t: '0, clip_r: '0, clip_b: '0};
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SURF_W: r_cfg.surf_w <= i_cfg_data;
                REG_SURF_H: r_cfg.surf_h <= i_cfg_data;
                REG_STRIDE: r_cfg.stride <= i_cfg_data;
                REG_BPP:    r_cfg.bpp    <= i_cfg_data[BPP_W-1:0];
                REG_CLIP_L: r_cfg.clip_l <= i_cfg_data;
                REG_CLIP_T: r_cfg.clip_t <= i_cfg_data;
                REG_CLIP_R: r_cfg.clip_r <= i_cfg_data;
                REG_CLIP_B: r_cfg.clip_b <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/bccs_front.sv
// Stage 1: source bounds check and rounding of the fixed-point destination.
`default_nettype none

module bccs_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bccs_pkg::t_cfg                    i_cfg,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [bccs_pkg::IN_W-1:0]  i_src_x,
    input  wire logic signed [bccs_pkg::IN_W-1:0]  i_src_y,
    input  wire logic signed [bccs_pkg::IN_W-1:0]  i_copy_width,
    input  wire logic signed [bccs_pkg::IN_W-1:0]  i_copy_height,
    input  wire logic signed [bccs_pkg::FIX_W-1:0] i_dest_x_fixed,
    input  wire logic signed [bccs_pkg::FIX_W-1:0] i_dest_y_fixed,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output bccs_pkg::t_geom                        o_geom
);
    import bccs_pkg::*;

    logic  r_vld;
    t_geom r_geom;
    t_geom n_geom;

    // Check the source corners and round the destination to whole pixels
    always_comb begin
        logic signed [SUM_W-1:0] xs_e;
        logic signed [SUM_W-1:0] ys_e;
        logic signed [SUM_W-1:0] w_e;
        logic signed [SUM_W-1:0] h_e;
        logic signed [SUM_W-1:0] xe;
        logic signed [SUM_W-1:0] ye;
        logic signed [SUM_W-1:0] sw_e;
        logic signed [SUM_W-1:0] sh_e;
        logic signed [FIX_W:0]   bx;
        logic signed [FIX_W:0]   by;
        logic signed [RND_W-1:0] rx;
        logic signed [RND_W-1:0] ry;
        xs_e = {{(SUM_W-IN_W){i_src_x[IN_W-1]}}, i_src_x};
        ys_e = {{(SUM_W-IN_W){i_src_y[IN_W-1]}}, i_src_y};
        w_e  = {{(SUM_W-IN_W){i_copy_width[IN_W-1]}}, i_copy_width};
        h_e  = {{(SUM_W-IN_W){i_copy_height[IN_W-1]}}, i_copy_height};
        xe   = xs_e + w_e;
        ye   = ys_e + h_e;
        sw_e = $signed({{(SUM_W-DIM_W){1'b0}}, i_cfg.surf_w});
        sh_e = $signed({{(SUM_W-DIM_W){1'b0}}, i_cfg.surf_h});

        n_geom.reject = xs_e[SUM_W-1] || (xs_e > sw_e)
                     || ys_e[SUM_W-1] || (ys_e > sh_e)
                     || xe[SUM_W-1]   || (xe > sw_e)
                     || ye[SUM_W-1]   || (ye > sh_e);

        bx = {i_dest_x_fixed[FIX_W-1], i_dest_x_fixed} + (FIX_W+1)'(1 << (FRAC_W - 1));
        by = {i_dest_y_fixed[FIX_W-1], i_dest_y_fixed} + (FIX_W+1)'(1 << (FRAC_W - 1));
        rx = bx[FIX_W:FRAC_W];
        ry = by[FIX_W:FRAC_W];

        n_geom.xs = {{(CLP_W-IN_W){i_src_x[IN_W-1]}}, i_src_x};
        n_geom.ys = {{(CLP_W-IN_W){i_src_y[IN_W-1]}}, i_src_y};
        n_geom.w  = {{(CLP_W-IN_W){i_copy_width[IN_W-1]}}, i_copy_width};
        n_geom.h  = {{(CLP_W-IN_W){i_copy_height[IN_W-1]}}, i_copy_height};
        n_geom.xd = {{(CLP_W-RND_W){rx[RND_W-1]}}, rx};
        n_geom.yd = {{(CLP_W-RND_W){ry[RND_W-1]}}, ry};
    end

    assign o_ready = !r_vld || i_ready;

    // Advance the valid bit whenever the stage can move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Load the payload on an accepted item, hold otherwise
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_geom <= n_geom;
        end
    end

    assign o_valid = r_vld;
    assign o_geom  = r_geom;

endmodule

`default_nettype wire

FILE: hdl/bccs_clip.sv
// Stages 2 and 3: scissor clipping of the destination, source shifted alike.
`default_nettype none

module bccs_clip (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bccs_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire bccs_pkg::t_geom i_geom,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output bccs_pkg::t_geom      o_geom
);
    import bccs_pkg::*;

    logic  r_vld2;
    logic  r_vld3;
    t_geom r_g2;
    t_geom r_g3;
    t_geom n_g2;
    t_geom n_g3;
    logic  rdy2;
    logic  rdy3;

    // Clip against the left and top edges
    always_comb begin
        logic signed [CLP_W-1:0] cl;
        logic signed [CLP_W-1:0] ct;
        logic signed [CLP_W-1:0] dx;
        logic signed [CLP_W-1:0] dy;
        cl   = $signed({{(CLP_W-DIM_W){1'b0}}, i_cfg.clip_l});
        ct   = $signed({{(CLP_W-DIM_W){1'b0}}, i_cfg.clip_t});
        dx   = cl - i_geom.xd;
        dy   = ct - i_geom.yd;
        n_g2 = i_geom;
        if (i_geom.xd < cl) begin
            n_g2.xd = cl;
            n_g2.xs = i_geom.xs + dx;
            n_g2.w  = i_geom.w - dx;
        end
        if (i_geom.yd < ct) begin
            n_g2.yd = ct;
            n_g2.ys = i_geom.ys + dy;
            n_g2.h  = i_geom.h - dy;
        end
    end

    // Clip against the right and bottom edges
    always_comb begin
        logic signed [CLP_W-1:0] cr;
        logic signed [CLP_W-1:0] cb;
        cr   = $signed({{(CLP_W-DIM_W){1'b0}}, i_cfg.clip_r});
        cb   = $signed({{(CLP_W-DIM_W){1'b0}}, i_cfg.clip_b});
        n_g3 = r_g2;
        if (r_g2.xd + r_g2.w > cr) begin
            n_g3.w = cr - r_g2.xd;
        end
        if (r_g2.yd + r_g2.h > cb) begin
            n_g3.h = cb - r_g2.yd;
        end
    end

    assign rdy3    = !r_vld3 || i_ready;
    assign rdy2    = !r_vld2 || rdy3;
    assign o_ready = rdy2;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_vld2 <= i_valid;
            end
            if (rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    // Load payloads with their valid bits
    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_g2 <= n_g2;
        end
        if (rdy3 && r_vld2) begin
            r_g3 <= n_g3;
        end
    end

    assign o_valid = r_vld3;
    assign o_geom  = r_g3;

endmodule

`default_nettype wire

FILE: hdl/bccs_offs.sv
// Stages 4 and 5: classify the item, form row products and byte offsets.
`default_nettype none

module bccs_offs (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bccs_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire bccs_pkg::t_geom i_geom,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output bccs_pkg::t_res       o_res
);
    import bccs_pkg::*;

    logic r_vld4;
    logic r_vld5;
    t_cls r_c4;
    t_cls n_c4;
    t_res r_r5;
    t_res n_r5;
    logic rdy4;
    logic rdy5;

    // Classify, multiply stride by row and width by pixel size
    always_comb begin
        logic                     empty;
        logic                     same;
        logic [DIM_W-1:0]         ys;
        logic [DIM_W-1:0]         yd;
        logic [DIM_W-1:0]         w;
        logic [DIM_W+BPP_W-1:0]   rb_full;
        empty = (i_geom.w[CLP_W-1] || (i_geom.w == '0))
             || (i_geom.h[CLP_W-1] || (i_geom.h == '0));
        same  = (i_geom.xs == i_geom.xd) && (i_geom.ys == i_geom.yd);
        ys    = i_geom.ys[DIM_W-1:0];
        yd    = i_geom.yd[DIM_W-1:0];
        w     = i_geom.w[DIM_W-1:0];

        priority if (i_geom.reject) begin
            n_c4.status = ST_OUTSIDE;
        end else if (empty) begin
            n_c4.status = ST_EMPTY;
        end else if (same) begin
            n_c4.status = ST_SAME;
        end else begin
            n_c4.status = ST_COPY;
        end

        priority if (i_geom.ys < i_geom.yd) begin
            n_c4.order = ORD_UP;
        end else if (i_geom.ys == i_geom.yd) begin
            n_c4.order = ORD_ROW_SAFE;
        end else begin
            n_c4.order = ORD_DOWN;
        end

        rb_full        = w * i_cfg.bpp;
        n_c4.prod_s    = i_cfg.stride * ys;
        n_c4.prod_d    = i_cfg.stride * yd;
        n_c4.xs        = i_geom.xs[DIM_W-1:0];
        n_c4.xd        = i_geom.xd[DIM_W-1:0];
        n_c4.row_bytes = rb_full[RB_W-1:0];
        n_c4.row_count = i_geom.h[DIM_W-1:0];
    end

    // Add the column, scale by pixel size, zero all but the status for a non-copy
    always_comb begin
        logic [OFS_W-1:0]       sum_s;
        logic [OFS_W-1:0]       sum_d;
        logic [OFS_W+BPP_W-1:0] full_s;
        logic [OFS_W+BPP_W-1:0] full_d;
        sum_s  = r_c4.prod_s + OFS_W'(r_c4.xs);
        sum_d  = r_c4.prod_d + OFS_W'(r_c4.xd);
        full_s = sum_s * i_cfg.bpp;
        full_d = sum_d * i_cfg.bpp;
        n_r5.status = r_c4.status;
        if (r_c4.status == ST_COPY) begin
            n_r5.src_offset = full_s[OFS_W-1:0];
            n_r5.dst_offset = full_d[OFS_W-1:0];
            n_r5.row_bytes  = r_c4.row_bytes;
            n_r5.row_count  = r_c4.row_count;
            n_r5.order      = r_c4.order;
        end else begin
            n_r5.src_offset = '0;
            n_r5.dst_offset = '0;
            n_r5.row_bytes  = '0;
            n_r5.row_count  = '0;
            n_r5.order      = ORD_DOWN;
        end
    end

    assign rdy5    = !r_vld5 || i_ready;
    assign rdy4    = !r_vld4 || rdy5;
    assign o_ready = rdy4;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (rdy4) begin
                r_vld4 <= i_valid;
            end
            if (rdy5) begin
                r_vld5 <= r_vld4;
            end
        end
    end

    // Load payloads with their valid bits
    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            r_c4 <= n_c4;
        end
        if (rdy5 && r_vld4) begin
            r_r5 <= n_r5;
        end
    end

    assign o_valid = r_vld5;
    assign o_res   = r_r5;

endmodule

`default_nettype wire

FILE: hdl/bccs_checker.sv
// Port-level checker for the copy-rectangle setup block, with its bind.
`default_nettype none

module bccs_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                o_stall,
    input  wire logic                                o_valid,
    input  wire logic                                i_stall,
    input  wire logic [bccs_pkg::STAT_W-1:0]         o_status,
    input  wire logic [bccs_pkg::OFS_W-1:0]          o_src_offset,
    input  wire logic [bccs_pkg::OFS_W-1:0]          o_dst_offset,
    input  wire logic [bccs_pkg::RB_W-1:0]           o_row_bytes,
    input  wire logic [bccs_pkg::DIM_W-1:0]          o_row_count,
    input  wire logic [bccs_pkg::ORD_W-1:0]          o_copy_order
);
    import bccs_pkg::*;

    // Drop the output valid after a reset cycle
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_src_offset)
            && $stable(o_dst_offset) && $stable(o_row_bytes) && $stable(o_row_count)
            && $stable(o_copy_order))
        else $error("stalled result changed");

    // Stall upstream only behind a valid, stalled result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room in the pipeline");

    // Zero every field but the status of a result that is not a copy
    a_noncopy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_COPY) |-> (o_src_offset == '0) && (o_dst_offset == '0)
            && (o_row_bytes == '0) && (o_row_count == '0) && (o_copy_order == ORD_DOWN))
        else $error("non-copy result carries data");

    // A copy always has rows and a defined order
    a_copy_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_COPY) |-> (o_row_count != '0)
            && ((o_copy_order == ORD_DOWN) || (o_copy_order == ORD_UP)
                || (o_copy_order == ORD_ROW_SAFE)))
        else $error("copy result without rows or with bad order");

endmodule

bind blit_copy_clip_setup bccs_checker u_bccs_checker (.*);

`default_nettype wire
